// ===== hw/rtl/gslc_pkg.sv =====
// shared types, constants and codes for the gps synced local clock
// no dependencies; every other file imports this package
`timescale 1ns / 1ps

package gslc_pkg;

    // millisecond counting
    localparam int unsigned TICKS_PER_MINUTE = 60000;
    localparam int MS_W = 16;
    localparam logic [MS_W-1:0] MS_LAST = MS_W'(TICKS_PER_MINUTE - 1);

    // minute of day
    localparam int MOD_W = 11;
    localparam logic [MOD_W-1:0] MINUTES_PER_DAY = 11'd1440;

    // field widths
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int CFG_W   = 5;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] STD_OFFSET_RESET  = 5'd1;
    localparam logic [CFG_W-1:0] SWITCH_HOUR_RESET = 5'd1;

    // months that carry a switch sunday
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;

    // zeller terms for day 31: d + (13 * (m + 1)) / 5
    localparam logic [8:0] ZBASE_MAR = 9'd41;
    localparam logic [8:0] ZBASE_OCT = 9'd59;

    // reciprocal multipliers for division by constants
    localparam logic [12:0] RECIP_100 = 13'd5243;   // shift 19, exact below 4096
    localparam int          RSH_100   = 19;
    localparam logic [8:0]  RECIP_7   = 9'd293;     // shift 11, exact below 512
    localparam int          RSH_7     = 11;
    localparam logic [10:0] RECIP_60  = 11'd1093;   // shift 16, exact below 1440
    localparam int          RSH_60    = 16;

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_FIX  = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        CFG_STD_OFFSET  = 1'b0,
        CFG_SWITCH_HOUR = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV100,
        S_ZSUM,
        S_WDAY,
        S_APPLY,
        S_TICK,
        S_HDIV,
        S_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic div100;
        logic zsum;
        logic wday;
        logic apply;
        logic tick;
        logic hdiv;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_fix;
        logic fix_new;
        logic out_free;
    } sts_t;

endpackage

// ===== hw/rtl/gslc_if.sv =====
// valid/ready channel interfaces for fix/tick items and local time results
// depends on gslc_pkg
`timescale 1ns / 1ps

interface gslc_in_if
    import gslc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               op;
    logic [HOUR_W-1:0]  fix_hours;
    logic [MIN_W-1:0]   fix_minutes;
    logic [DAY_W-1:0]   fix_day;
    logic [MONTH_W-1:0] fix_month;
    logic [YEAR_W-1:0]  fix_year;

    modport source (output valid, op, fix_hours, fix_minutes, fix_day, fix_month,
                    fix_year, input ready);
    modport sink   (input valid, op, fix_hours, fix_minutes, fix_day, fix_month,
                    fix_year, output ready);
endinterface

interface gslc_out_if
    import gslc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HOUR_W-1:0] local_hours;
    logic [MIN_W-1:0]  local_minutes;
    logic              time_valid;
    logic              dst_active;

    modport source (output valid, local_hours, local_minutes, time_valid, dst_active,
                    input ready);
    modport sink   (input valid, local_hours, local_minutes, time_valid, dst_active,
                    output ready);
endinterface

// ===== hw/rtl/gslc_ctrl.sv =====
// controller state machine: sequences one item through the datapath
// depends on gslc_pkg
`timescale 1ns / 1ps

module gslc_ctrl
    import gslc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DIV100;
                end
            end
            S_DIV100:
            begin
                if (!sts.is_fix)
                begin
                    state_next = S_TICK;
                end
                else if (sts.fix_new)
                begin
                    state_next = S_ZSUM;
                end
                else
                begin
                    state_next = S_HDIV;
                end
            end
            S_ZSUM:  state_next = S_WDAY;
            S_WDAY:  state_next = S_APPLY;
            S_APPLY: state_next = S_HDIV;
            S_TICK:  state_next = S_HDIV;
            S_HDIV:  state_next = S_OUT;
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_DIV100: cmd.div100 = 1'b1;
            S_ZSUM:   cmd.zsum   = 1'b1;
            S_WDAY:   cmd.wday   = 1'b1;
            S_APPLY:  cmd.apply  = 1'b1;
            S_TICK:   cmd.tick   = 1'b1;
            S_HDIV:   cmd.hdiv   = 1'b1;
            S_OUT:    cmd.out_load = sts.out_free;
            default:  cmd = '0;
        endcase
    end

    // a held result blocks the controller in the output state
    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !sts.out_free) |=> state_reg == S_OUT)
        else $error("controller left output state while result slot busy");

    // input is taken only while idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("input ready outside idle state");

    // an input transfer always starts the year split
    a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == S_DIV100)
        else $error("input transfer did not start the sequence");

endmodule

// ===== hw/rtl/gslc_dp.sv =====
// datapath: captured item, dst weekday arithmetic, clock state, result register
// depends on gslc_pkg
`timescale 1ns / 1ps

module gslc_dp
    import gslc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration writes
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    // input item payload
    input  logic                op,
    input  logic [HOUR_W-1:0]   fix_hours,
    input  logic [MIN_W-1:0]    fix_minutes,
    input  logic [DAY_W-1:0]    fix_day,
    input  logic [MONTH_W-1:0]  fix_month,
    input  logic [YEAR_W-1:0]   fix_year,
    // result side
    input  logic                out_ready,
    output logic                out_valid,
    output logic [HOUR_W-1:0]   local_hours,
    output logic [MIN_W-1:0]    local_minutes,
    output logic                time_valid,
    output logic                dst_active,
    // controller link
    input  cmd_t                cmd,
    output sts_t                sts
);

    // configuration
    logic [CFG_W-1:0] std_off_reg;
    logic [CFG_W-1:0] sw_hour_reg;

    // captured item
    logic               op_reg;
    logic [HOUR_W-1:0]  hr_reg;
    logic [MIN_W-1:0]   min_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [MONTH_W-1:0] mon_reg;
    logic [YEAR_W-1:0]  yr_reg;

    // weekday pipeline
    logic [5:0] j_reg,    j_next;
    logic [6:0] k_reg,    k_next;
    logic [8:0] zsum_reg, zsum_next;
    logic [4:0] ls_reg,   ls_next;

    // clock state
    logic             synced_reg;
    logic [MOD_W-1:0] last_reg;
    logic [MOD_W-1:0] lmod_reg, lmod_next;
    logic [MS_W-1:0]  ms_reg,   ms_next;
    logic             summer_reg, summer_next;
    logic [HOUR_W-1:0] hq_reg,  hq_next;

    // result register
    logic               out_valid_reg;
    logic [HOUR_W-1:0]  out_hours_reg;
    logic [MIN_W-1:0]   out_minutes_reg;
    logic               out_tv_reg;
    logic               out_dst_reg;

    logic [MOD_W-1:0]  utc_mod;
    logic [24:0]       prod100;
    logic [17:0]       prod7;
    logic [5:0]        q7;
    logic [2:0]        h7;
    logic [2:0]        wday;
    logic [5:0]        off;
    logic [6:0]        hsum;
    logic [4:0]        lh;
    logic [MOD_W-1:0]  lm_raw;
    logic [21:0]       prod60;
    logic [MOD_W-1:0]  min_rem;
    logic [MOD_W:0]    lmod_inc;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            std_off_reg <= STD_OFFSET_RESET;
            sw_hour_reg <= SWITCH_HOUR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_STD_OFFSET:  std_off_reg <= cfg_data;
                CFG_SWITCH_HOUR: sw_hour_reg <= cfg_data;
                default:         std_off_reg <= std_off_reg;
            endcase
        end
    end

    // item capture on input transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= op;
            hr_reg  <= fix_hours;
            min_reg <= fix_minutes;
            day_reg <= fix_day;
            mon_reg <= fix_month;
            yr_reg  <= fix_year;
        end
    end

    // utc minute of day of the captured fix
    assign utc_mod = MOD_W'(hr_reg) * MOD_W'(60) + MOD_W'(min_reg);

    // year split into century and year of century
    always_comb
    begin
        prod100 = 25'(yr_reg) * 25'(RECIP_100);
        j_next  = prod100[RSH_100 +: 6];
        k_next  = 7'(yr_reg - 12'(j_next) * 12'd100);
    end

    // zeller sum for day 31 of march or october
    always_comb
    begin
        zsum_next = ((mon_reg == MONTH_MAR) ? ZBASE_MAR : ZBASE_OCT)
                  + 9'(k_reg) + 9'(k_reg >> 2) + 9'(j_reg >> 2) + 9'(j_reg) * 9'd5;
    end

    // weekday of day 31 and day of the last sunday
    always_comb
    begin
        prod7   = 18'(zsum_reg) * 18'(RECIP_7);
        q7      = prod7[RSH_7 +: 6];
        h7      = 3'(zsum_reg - 9'(q7) * 9'd7);
        wday    = (h7 == 3'd0) ? 3'd6 : h7 - 3'd1;
        ls_next = 5'd31 - 5'(wday);
    end

    // summer decision and new local base
    always_comb
    begin
        if (mon_reg < MONTH_MAR || mon_reg > MONTH_OCT)
        begin
            summer_next = 1'b0;
        end
        else if (mon_reg > MONTH_MAR && mon_reg < MONTH_OCT)
        begin
            summer_next = 1'b1;
        end
        else if (mon_reg == MONTH_MAR)
        begin
            if (day_reg != ls_reg)
            begin
                summer_next = day_reg > ls_reg;
            end
            else
            begin
                summer_next = hr_reg >= sw_hour_reg;
            end
        end
        else
        begin
            if (day_reg != ls_reg)
            begin
                summer_next = day_reg < ls_reg;
            end
            else
            begin
                summer_next = hr_reg < sw_hour_reg;
            end
        end

        off  = 6'(std_off_reg) + 6'(summer_next);
        hsum = 7'(hr_reg) + 7'(off);
        if (hsum >= 7'd48)
        begin
            lh = 5'(hsum - 7'd48);
        end
        else if (hsum >= 7'd24)
        begin
            lh = 5'(hsum - 7'd24);
        end
        else
        begin
            lh = 5'(hsum);
        end
        lm_raw = MOD_W'(lh) * MOD_W'(60) + MOD_W'(min_reg);
    end

    // local base load on apply, millisecond tick and minute advance
    always_comb
    begin
        lmod_inc = {1'b0, lmod_reg} + 12'd1;
        lmod_next = lmod_reg;
        ms_next   = ms_reg;
        if (cmd.apply)
        begin
            lmod_next = (lm_raw >= MINUTES_PER_DAY) ? lm_raw - MINUTES_PER_DAY : lm_raw;
            ms_next   = '0;
        end
        else if (cmd.tick && synced_reg)
        begin
            if (ms_reg >= MS_LAST)
            begin
                ms_next   = '0;
                lmod_next = (lmod_inc >= {1'b0, MINUTES_PER_DAY}) ? '0 : lmod_inc[MOD_W-1:0];
            end
            else
            begin
                ms_next = ms_reg + 1'b1;
            end
        end
    end

    // hour of the local minute of day
    always_comb
    begin
        prod60  = 22'(lmod_reg) * 22'(RECIP_60);
        hq_next = prod60[RSH_60 +: HOUR_W];
        min_rem = lmod_reg - MOD_W'(hq_reg) * MOD_W'(60);
    end

    // weekday pipeline registers and hour quotient register
    always_ff @(posedge clk)
    begin
        if (cmd.div100)
        begin
            j_reg <= j_next;
            k_reg <= k_next;
        end
        if (cmd.zsum)
        begin
            zsum_reg <= zsum_next;
        end
        if (cmd.wday)
        begin
            ls_reg <= ls_next;
        end
        if (cmd.hdiv)
        begin
            hq_reg <= hq_next;
        end
    end

    // clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg <= 1'b0;
            last_reg   <= '0;
            lmod_reg   <= '0;
            ms_reg     <= '0;
            summer_reg <= 1'b0;
        end
        else
        begin
            lmod_reg <= lmod_next;
            ms_reg   <= ms_next;
            if (cmd.apply)
            begin
                synced_reg <= 1'b1;
                last_reg   <= utc_mod;
                summer_reg <= summer_next;
            end
        end
    end

    // result register, freed by an output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_hours_reg   <= synced_reg ? hq_reg : '0;
            out_minutes_reg <= synced_reg ? min_rem[MIN_W-1:0] : '0;
            out_tv_reg      <= synced_reg;
            out_dst_reg     <= synced_reg & summer_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign local_hours   = out_hours_reg;
    assign local_minutes = out_minutes_reg;
    assign time_valid    = out_tv_reg;
    assign dst_active    = out_dst_reg;

    // status to controller
    assign sts.is_fix   = (op_t'(op_reg) == OP_FIX);
    assign sts.fix_new  = !synced_reg || (utc_mod != last_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    a_ms_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !synced_reg |-> (ms_reg == '0 && !summer_reg))
        else $error("clock state moved before first fix");

    a_lmod_range: assert property (@(posedge clk) disable iff (!rst_n)
        lmod_reg < MINUTES_PER_DAY)
        else $error("local minute of day out of range");

    a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
        ms_reg <= MS_LAST)
        else $error("millisecond count out of range");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result load did not raise valid");

endmodule

// ===== hw/rtl/gps_synced_local_clock_core.sv =====
// gps synced local clock with european dst: top level
// an item runs the year split, then the tick step (tick) or the zeller sum, weekday and apply
// steps (new fix) or none (repeat fix), then the hour division and the result load
// one item at a time: input is taken only in idle, once the result is in the one result slot
// input is taken again while the previous result still waits in the output register
// reset: async active low; clock unsynced, offset and switch hour both 1
`timescale 1ns / 1ps

module gps_synced_local_clock_core
    import gslc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    gslc_in_if.sink          item,
    gslc_out_if.source       result
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    // sequencing
    gslc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign item.ready = in_ready;

    // arithmetic and state
    gslc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .op            (item.op),
        .fix_hours     (item.fix_hours),
        .fix_minutes   (item.fix_minutes),
        .fix_day       (item.fix_day),
        .fix_month     (item.fix_month),
        .fix_year      (item.fix_year),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .local_hours   (result.local_hours),
        .local_minutes (result.local_minutes),
        .time_valid    (result.time_valid),
        .dst_active    (result.dst_active),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
